// ----- rtl/core/pas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants for the point attractor particle step pipeline.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int NUM_AXES = 3;

  // one particle item in, one advanced particle item out
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } pas_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } pas_out_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ATTR_X,
    CFG_ATTR_Y,
    CFG_ATTR_Z,
    CFG_STRENGTH,
    CFG_SOFTENING,
    CFG_DAMPING,
    CFG_TIME_STEP,
    CFG_MODE
  } pas_cfg_idx_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } pas_axis_t;

  // per-item context that travels down the pipe
  typedef struct packed {
    pas_in_t               item;
    logic [NUM_AXES-1:0]   neg;
    logic                  act;
  } pas_ctx_t;

  // mode register bits
  localparam int MODE_ATTRACT = 0;
  localparam int MODE_PAUSE   = 1;

  // reset values
  localparam logic [30:0] STRENGTH_RST  = 31'd65536;
  localparam logic [30:0] SOFTENING_RST = 31'd6554;
  localparam logic [16:0] DAMPING_RST   = 17'd65536;
  localparam logic [30:0] TIME_STEP_RST = 31'd1092;
  localparam logic [1:0]  MODE_RST      = 2'd1;

  // magnitude caps
  localparam logic [50:0] TERM_CAP = 51'd1 << 50;
  localparam logic [47:0] VEL_CAP  = 48'd1 << 47;

  // stage map
  localparam int SQRT_N  = 32;
  localparam int DIV1_N  = 31;
  localparam int DIV2_N  = 47;
  localparam int ST_SUM  = 2;
  localparam int ST_SQRT = ST_SUM + 1;
  localparam int ST_DIV1 = ST_SQRT + SQRT_N;
  localparam int ST_MULS = ST_DIV1 + DIV1_N;
  localparam int ST_DIV2 = ST_MULS + 1;
  localparam int ST_T1   = ST_DIV2 + DIV2_N;
  localparam int ST_T2   = ST_T1 + 1;
  localparam int ST_T3   = ST_T2 + 1;
  localparam int ST_T4   = ST_T3 + 1;
  localparam int N_STAGE = ST_T4 + 1;

endpackage

// ----- rtl/core/point_attractor_particle_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_attractor_particle_step
// Advances one particle per item by one time step under a softened point
// attractor, in Q16.16 fixed point with saturated results, unless paused.
// ----------------------------------------------------------------------------
// Takes one particle item per clock while in_ready is high and returns one
// result item per item, in order. The pipe holds the 32-stage square root of
// the offset length, the 31-stage direction divider and the 47-stage
// acceleration divider. The whole pipe advances together whenever the output
// register is empty or being taken.
// Configuration writes are taken every cycle (cfg_ready is tied high) and must
// only be issued while no item is in flight.
module point_attractor_particle_step import pas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pas_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pas_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // axis select helpers
  function automatic logic [31:0] axis_pos(input pas_in_t it, input pas_axis_t ax);
    logic [31:0] r;
    unique case (ax)
      AX_X:    r = it.pos_x;
      AX_Y:    r = it.pos_y;
      AX_Z:    r = it.pos_z;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] axis_vel(input pas_in_t it, input pas_axis_t ax);
    logic [31:0] r;
    unique case (ax)
      AX_X:    r = it.vel_x;
      AX_Y:    r = it.vel_y;
      AX_Z:    r = it.vel_z;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat53(input logic [52:0] x);
    logic [31:0] r;
    if (x[52] && !(&x[52:31])) begin
      r = 32'h8000_0000;
    end else if (!x[52] && (|x[52:31])) begin
      r = 32'h7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [31:0] attr_r [NUM_AXES];
  logic [30:0] strength_r;
  logic [30:0] softening_r;
  logic [16:0] damping_r;
  logic [30:0] time_step_r;
  logic [1:0]  mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r[0]   <= '0;
      attr_r[1]   <= '0;
      attr_r[2]   <= '0;
      strength_r  <= STRENGTH_RST;
      softening_r <= SOFTENING_RST;
      damping_r   <= DAMPING_RST;
      time_step_r <= TIME_STEP_RST;
      mode_r      <= MODE_RST;
    end else if (cfg_valid) begin
      unique case (pas_cfg_idx_t'(cfg_index))
        CFG_ATTR_X:    attr_r[0]   <= cfg_data;
        CFG_ATTR_Y:    attr_r[1]   <= cfg_data;
        CFG_ATTR_Z:    attr_r[2]   <= cfg_data;
        CFG_STRENGTH:  strength_r  <= cfg_data[30:0];
        CFG_SOFTENING: softening_r <= cfg_data[30:0];
        CFG_DAMPING:   damping_r   <= cfg_data[16:0];
        CFG_TIME_STEP: time_step_r <= cfg_data[30:0];
        CFG_MODE:      mode_r      <= cfg_data[1:0];
      endcase
    end
  end

  // pipe control: everything moves when the output register can take an item
  logic     en;
  logic     out_valid_r;
  pas_out_t out_data_r;
  logic     vld_r [N_STAGE];
  pas_ctx_t ctx_r [N_STAGE];
  pas_ctx_t ctx0_c;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_STAGE; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N_STAGE; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx0_c;
      for (int k = 1; k < N_STAGE; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  // stage 0: offset to attractor and its magnitude
  logic [NUM_AXES-1:0] neg_c;
  logic [NUM_AXES-1:0] nz_c;
  logic [31:0]         m0_r [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_s0
    logic [31:0] p;
    logic [32:0] r;
    logic [32:0] nr;
    assign p        = axis_pos(in_data, pas_axis_t'(i));
    assign r        = {attr_r[i][31], attr_r[i]} - {p[31], p};
    assign nr       = 33'd0 - r;
    assign neg_c[i] = r[32];
    assign nz_c[i]  = |r;
    always_ff @(posedge clk) begin
      if (en) begin
        m0_r[i] <= r[32] ? nr[31:0] : r[31:0];
      end
    end
  end

  assign ctx0_c = '{item: in_data, neg: neg_c,
                    act: mode_r[MODE_ATTRACT] && (|nz_c)};

  // stage 1: squares, and magnitudes for the length (halved if any top bit is set)
  logic        big_c;
  logic [63:0] sq1_r  [NUM_AXES];
  logic [61:0] sqh1_r [NUM_AXES];
  logic [30:0] mh1_r  [NUM_AXES];

  assign big_c = m0_r[0][31] | m0_r[1][31] | m0_r[2][31];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_s1
    logic [30:0] mh;
    assign mh = big_c ? m0_r[i][31:1] : m0_r[i][30:0];
    always_ff @(posedge clk) begin
      if (en) begin
        sq1_r[i]  <= 64'(m0_r[i]) * 64'(m0_r[i]);
        sqh1_r[i] <= 62'(mh) * 62'(mh);
        mh1_r[i]  <= mh;
      end
    end
  end

  // stage 2: softened squared distance and sum for the length
  logic [65:0] sum3_c;
  logic [50:0] dsum_c;
  logic [50:0] d2_r;
  logic [63:0] sumsq2_r;
  logic [30:0] mh2_r [NUM_AXES];

  assign sum3_c = 66'(sq1_r[0]) + 66'(sq1_r[1]) + 66'(sq1_r[2]);
  assign dsum_c = 51'(sum3_c[65:16]) + 51'(softening_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r     <= (dsum_c == '0) ? 51'd1 : dsum_c;
      sumsq2_r <= 64'(sqh1_r[0]) + 64'(sqh1_r[1]) + 64'(sqh1_r[2]);
      mh2_r    <= mh1_r;
    end
  end

  // square root, one result bit per stage
  logic [63:0] sx_r   [SQRT_N];
  logic [63:0] sres_r [SQRT_N];
  logic [50:0] sd_r   [SQRT_N];
  logic [30:0] smh_r  [SQRT_N][NUM_AXES];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [63:0] SBIT = 64'd1 << (2 * (SQRT_N - 1 - k));
    logic [63:0] x_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    logic [50:0] d_in;
    logic [30:0] mh_in [NUM_AXES];
    logic        ge;
    if (k == 0) begin : g_first
      assign x_in   = sumsq2_r;
      assign res_in = '0;
      assign d_in   = d2_r;
      assign mh_in  = mh2_r;
    end else begin : g_next
      assign x_in   = sx_r[k-1];
      assign res_in = sres_r[k-1];
      assign d_in   = sd_r[k-1];
      assign mh_in  = smh_r[k-1];
    end
    assign trial = res_in + SBIT;
    assign ge    = x_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k]   <= ge ? x_in - trial : x_in;
        sres_r[k] <= ge ? (res_in >> 1) + SBIT : res_in >> 1;
        sd_r[k]   <= d_in;
        smh_r[k]  <= mh_in;
      end
    end
  end

  // length, never zero as a divisor
  logic [31:0] lenraw_c;
  logic [31:0] len_c;

  assign lenraw_c = sres_r[SQRT_N-1][31:0];
  assign len_c    = (lenraw_c == '0) ? 32'd1 : lenraw_c;

  // unit direction: u = (m << 30) / len, one quotient bit per stage
  logic [31:0] q1rem_r [DIV1_N][NUM_AXES];
  logic [30:0] q1q_r   [DIV1_N][NUM_AXES];
  logic [50:0] q1d_r   [DIV1_N];
  logic [31:0] q1len_r [DIV1_N];

  for (genvar j = 0; j < DIV1_N; j++) begin : g_div1
    logic [31:0] len_in;
    logic [50:0] d_in;
    if (j == 0) begin : g_first
      assign len_in = len_c;
      assign d_in   = sd_r[SQRT_N-1];
    end else begin : g_next
      assign len_in = q1len_r[j-1];
      assign d_in   = q1d_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q1len_r[j] <= len_in;
        q1d_r[j]   <= d_in;
      end
    end
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      logic [32:0] t;
      logic [30:0] q_in;
      logic        ge;
      if (j == 0) begin : g_first
        assign t    = {2'b00, smh_r[SQRT_N-1][i]};
        assign q_in = '0;
      end else begin : g_next
        assign t    = {q1rem_r[j-1][i], 1'b0};
        assign q_in = q1q_r[j-1][i];
      end
      assign ge = t >= {1'b0, len_in};
      always_ff @(posedge clk) begin
        if (en) begin
          q1rem_r[j][i] <= ge ? 32'(t - {1'b0, len_in}) : t[31:0];
          q1q_r[j][i]   <= {q_in[29:0], ge};
        end
      end
    end
  end

  // strength times unit direction
  logic [61:0] prod_r [NUM_AXES];
  logic [50:0] md_r;

  always_ff @(posedge clk) begin
    if (en) begin
      md_r <= q1d_r[DIV1_N-1];
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_muls
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[i] <= 62'(strength_r) * 62'(q1q_r[DIV1_N-1][i]);
      end
    end
  end

  // acceleration: prod / (d << 14), one quotient bit per stage
  logic [64:0] q2rem_r [DIV2_N][NUM_AXES];
  logic [46:0] q2xq_r  [DIV2_N][NUM_AXES];
  logic [50:0] q2d_r   [DIV2_N];

  for (genvar j = 0; j < DIV2_N; j++) begin : g_div2
    logic [50:0] d_in;
    logic [65:0] e;
    if (j == 0) begin : g_first
      assign d_in = md_r;
    end else begin : g_next
      assign d_in = q2d_r[j-1];
    end
    assign e = {1'b0, d_in, 14'd0};
    always_ff @(posedge clk) begin
      if (en) begin
        q2d_r[j] <= d_in;
      end
    end
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      logic [64:0] rem_in;
      logic [46:0] xq_in;
      logic [65:0] t;
      logic        ge;
      if (j == 0) begin : g_first
        assign rem_in = 65'(prod_r[i][61:47]);
        assign xq_in  = prod_r[i][46:0];
      end else begin : g_next
        assign rem_in = q2rem_r[j-1][i];
        assign xq_in  = q2xq_r[j-1][i];
      end
      assign t  = {rem_in, xq_in[46]};
      assign ge = t >= e;
      always_ff @(posedge clk) begin
        if (en) begin
          q2rem_r[j][i] <= ge ? 65'(t - e) : t[64:0];
          q2xq_r[j][i]  <= {xq_in[45:0], ge};
        end
      end
    end
  end

  // integration per axis
  logic [61:0] p1_r   [NUM_AXES];
  logic [46:0] p2_r   [NUM_AXES];
  logic [62:0] vdtf_r [NUM_AXES];
  logic [50:0] adt2_r [NUM_AXES];
  logic [46:0] vdt2_r [NUM_AXES];
  logic [56:0] h1_r   [NUM_AXES];
  logic [55:0] h0_r   [NUM_AXES];
  logic [47:0] vm3_r  [NUM_AXES];
  logic        vneg3_r [NUM_AXES];
  logic [46:0] vdt3_r [NUM_AXES];
  logic [50:0] half4_r [NUM_AXES];
  logic [64:0] vsc4_r [NUM_AXES];
  logic        vneg4_r [NUM_AXES];
  logic [46:0] vdt4_r [NUM_AXES];
  logic [31:0] newp_c [NUM_AXES];
  logic [31:0] newv_c [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_int
    logic [46:0] am;
    logic [31:0] v1;
    logic [31:0] nv1;
    logic [31:0] va;
    logic [62:0] adtf;
    logic [31:0] v3;
    logic [52:0] sa;
    logic [52:0] nvs;
    logic [52:0] nmag;
    logic [81:0] hs;
    logic [64:0] halff;
    logic [31:0] p5;
    logic [31:0] v5;
    logic [52:0] svd;
    logic [52:0] sh;
    logic [52:0] np;
    logic [48:0] vsh;
    logic [52:0] nvv;

    // t1: split products with the time step
    assign am  = ctx_r[ST_T1-1].act ? q2xq_r[DIV2_N-1][i] : '0;
    assign v1  = axis_vel(ctx_r[ST_T1-1].item, pas_axis_t'(i));
    assign nv1 = 32'd0 - v1;
    assign va  = v1[31] ? nv1 : v1;
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[i]   <= 62'(am[46:16]) * 62'(time_step_r);
        p2_r[i]   <= 47'(am[15:0]) * 47'(time_step_r);
        vdtf_r[i] <= 63'(va) * 63'(time_step_r);
      end
    end

    // t2: a*dt and v*dt
    assign adtf = 63'(p1_r[i]) + 63'(p2_r[i][46:16]);
    always_ff @(posedge clk) begin
      if (en) begin
        adt2_r[i] <= (adtf > 63'(TERM_CAP)) ? TERM_CAP : adtf[50:0];
        vdt2_r[i] <= vdtf_r[i][62:16];
      end
    end

    // t3: half-term products and new velocity before damping
    assign v3   = axis_vel(ctx_r[ST_T3-1].item, pas_axis_t'(i));
    assign sa   = ctx_r[ST_T3-1].neg[i] ? 53'd0 - 53'(adt2_r[i]) : 53'(adt2_r[i]);
    assign nvs  = {{21{v3[31]}}, v3} + sa;
    assign nmag = nvs[52] ? 53'd0 - nvs : nvs;
    always_ff @(posedge clk) begin
      if (en) begin
        h1_r[i]    <= 57'(adt2_r[i][50:25]) * 57'(time_step_r);
        h0_r[i]    <= 56'(adt2_r[i][24:0]) * 56'(time_step_r);
        vm3_r[i]   <= (nmag > 53'(VEL_CAP)) ? VEL_CAP : nmag[47:0];
        vneg3_r[i] <= nvs[52];
        vdt3_r[i]  <= vdt2_r[i];
      end
    end

    // t4: half a dt squared, damping
    assign hs    = {h1_r[i], 25'd0} + 82'(h0_r[i]);
    assign halff = hs[81:17];
    always_ff @(posedge clk) begin
      if (en) begin
        half4_r[i] <= (halff > 65'(TERM_CAP)) ? TERM_CAP : halff[50:0];
        vsc4_r[i]  <= 65'(vm3_r[i]) * 65'(damping_r);
        vneg4_r[i] <= vneg3_r[i];
        vdt4_r[i]  <= vdt3_r[i];
      end
    end

    // output: signed sums and saturation
    assign p5  = axis_pos(ctx_r[ST_T4].item, pas_axis_t'(i));
    assign v5  = axis_vel(ctx_r[ST_T4].item, pas_axis_t'(i));
    assign svd = v5[31] ? 53'd0 - 53'(vdt4_r[i]) : 53'(vdt4_r[i]);
    assign sh  = ctx_r[ST_T4].neg[i] ? 53'd0 - 53'(half4_r[i]) : 53'(half4_r[i]);
    assign np  = {{21{p5[31]}}, p5} + svd + sh;
    assign vsh = vsc4_r[i][64:16];
    assign nvv = vneg4_r[i] ? 53'd0 - 53'(vsh) : 53'(vsh);
    assign newp_c[i] = sat53(np);
    assign newv_c[i] = sat53(nvv);
  end

  // output register, paused items pass through untouched
  pas_out_t out_c;

  always_comb begin
    if (mode_r[MODE_PAUSE]) begin
      out_c.new_pos_x = ctx_r[ST_T4].item.pos_x;
      out_c.new_pos_y = ctx_r[ST_T4].item.pos_y;
      out_c.new_pos_z = ctx_r[ST_T4].item.pos_z;
      out_c.new_vel_x = ctx_r[ST_T4].item.vel_x;
      out_c.new_vel_y = ctx_r[ST_T4].item.vel_y;
      out_c.new_vel_z = ctx_r[ST_T4].item.vel_z;
    end else begin
      out_c.new_pos_x = newp_c[0];
      out_c.new_pos_y = newp_c[1];
      out_c.new_pos_z = newp_c[2];
      out_c.new_vel_x = newv_c[0];
      out_c.new_vel_y = newv_c[1];
      out_c.new_vel_z = newv_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[ST_T4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_c;
    end
  end

endmodule
